// ----- sv/three_axis_step_rate_generator_defines.svh -----
// Assertion macros shared by the step rate generator RTL.
`ifndef THREE_AXIS_STEP_RATE_GENERATOR_DEFINES_SVH
`define THREE_AXIS_STEP_RATE_GENERATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define TSRG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("step rate generator check failed");

// Check that a condition in one cycle implies a consequence in the next.
`define TSRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("step rate generator sequence check failed");

`endif

// ----- sv/tsrg_pkg.sv -----
// Package with the constants, types and register codes of the step rate generator.
package tsrg_pkg;

   // Axis and time geometry
   localparam int NUM_AXES  = 3;
   localparam int IN_AXES   = 3;
   localparam int LANES     = (NUM_AXES < IN_AXES) ? NUM_AXES : IN_AXES;
   localparam int TIME_BITS = 32;

   // Speed format and interval arithmetic
   localparam int SPEED_BITS    = 16;
   localparam int FRAC_BITS     = 14;
   localparam int MAG_BITS      = FRAC_BITS + 1;
   localparam int DZ_BITS       = 15;
   localparam int IVL_BITS      = 16;
   localparam int PROD_BITS     = IVL_BITS + MAG_BITS;
   localparam int INTERVAL_BITS = IVL_BITS + 1;
   localparam int CMP_BITS      = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;
   localparam logic [MAG_BITS-1:0] FULL_SPEED = MAG_BITS'(1 << FRAC_BITS);

   // Configuration register map
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEAD_ZONE     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INTERVAL_SPAN = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UPDATE_PERIOD = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SWAP_XY       = 3'd4;

   // Register reset values
   localparam logic [DZ_BITS-1:0]  RST_DEAD_ZONE     = 15'd164;
   localparam logic [IVL_BITS-1:0] RST_BASE_INTERVAL = 16'd5000;
   localparam logic [IVL_BITS-1:0] RST_INTERVAL_SPAN = 16'd10000;
   localparam logic [IVL_BITS-1:0] RST_UPDATE_PERIOD = 16'd500;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic signed [SPEED_BITS-1:0] speed_type;

   typedef struct packed {
      logic [DZ_BITS-1:0]  dead_zone;
      logic [IVL_BITS-1:0] base_interval;
      logic [IVL_BITS-1:0] interval_span;
      logic [IVL_BITS-1:0] update_period;
      logic                swap_xy;
   } cfg_type;

   // Commit control sent from the merge stage to every lane
   typedef struct packed {
      logic commit;
      logic take;
   } lane_ctl_type;

   // Per-lane result for the item in the commit stage
   typedef struct packed {
      logic dir;
      logic step;
   } lane_res_type;

endpackage

// ----- sv/tsrg_req_if.sv -----
// Request channel interface: timestamp and three axis speeds.
interface tsrg_req_if;
   logic                valid;
   logic                ready;
   logic [31:0]         now_us;
   logic signed [15:0]  speed_x;
   logic signed [15:0]  speed_y;
   logic signed [15:0]  speed_z;

   modport source (output valid, output now_us, output speed_x, output speed_y,
                   output speed_z, input ready);
   modport sink   (input valid, input now_us, input speed_x, input speed_y,
                   input speed_z, output ready);
endinterface

// ----- sv/tsrg_rsp_if.sv -----
// Response channel interface: update flag, latched directions and step strobes.
interface tsrg_rsp_if;
   logic valid;
   logic ready;
   logic update_taken;
   logic dir_x;
   logic dir_y;
   logic dir_z;
   logic step_x;
   logic step_y;
   logic step_z;

   modport source (output valid, output update_taken, output dir_x, output dir_y,
                   output dir_z, output step_x, output step_y, output step_z,
                   input ready);
   modport sink   (input valid, input update_taken, input dir_x, input dir_y,
                   input dir_z, input step_x, input step_y, input step_z,
                   output ready);
endinterface

// ----- sv/tsrg_lane.sv -----
// One axis lane: speed to interval mapping, step time compare and direction latch.
module tsrg_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  tsrg_pkg::speed_type    speed,
   input  tsrg_pkg::cfg_type      cfg,
   input  tsrg_pkg::time_type     now,
   input  tsrg_pkg::lane_ctl_type ctl,
   output tsrg_pkg::lane_res_type res
);

   logic [tsrg_pkg::SPEED_BITS:0]      mag_full;
   logic [tsrg_pkg::MAG_BITS-1:0]      mag_sat;
   logic [tsrg_pkg::MAG_BITS-1:0]      remain;
   logic                               stop_in;
   logic [tsrg_pkg::PROD_BITS-1:0]     prod_in;
   logic                               dir_s1_ff;
   logic                               stop_s1_ff;
   logic [tsrg_pkg::PROD_BITS-1:0]     prod_s1_ff;
   logic                               dir_latch_ff;
   tsrg_pkg::time_type                 step_time_ff;
   logic [tsrg_pkg::INTERVAL_BITS-1:0] interval;
   tsrg_pkg::time_type                 elapsed;
   logic                               step;

   // Magnitude, dead zone, saturation and span product
   always_comb begin
      mag_full = speed[tsrg_pkg::SPEED_BITS-1]
               ? ({(tsrg_pkg::SPEED_BITS+1){1'b0}} - {speed[tsrg_pkg::SPEED_BITS-1], speed})
               : {1'b0, speed};
      stop_in  = mag_full < (tsrg_pkg::SPEED_BITS+1)'(cfg.dead_zone);
      mag_sat  = (mag_full > (tsrg_pkg::SPEED_BITS+1)'(tsrg_pkg::FULL_SPEED))
               ? tsrg_pkg::FULL_SPEED : mag_full[tsrg_pkg::MAG_BITS-1:0];
      remain   = tsrg_pkg::FULL_SPEED - mag_sat;
      prod_in  = tsrg_pkg::PROD_BITS'(cfg.interval_span) * tsrg_pkg::PROD_BITS'(remain);
   end

   // Hold the mapped speed for the commit stage
   always_ff @(posedge clock) begin
      if (load) begin
         dir_s1_ff  <= !speed[tsrg_pkg::SPEED_BITS-1];
         stop_s1_ff <= stop_in;
         prod_s1_ff <= prod_in;
      end
   end

   // Interval and elapsed time compare for the item in the commit stage
   always_comb begin
      interval = tsrg_pkg::INTERVAL_BITS'(cfg.base_interval)
               + tsrg_pkg::INTERVAL_BITS'(prod_s1_ff[tsrg_pkg::PROD_BITS-1:tsrg_pkg::FRAC_BITS]);
      elapsed  = now - step_time_ff;
      step     = ctl.take && !stop_s1_ff
               && (tsrg_pkg::CMP_BITS'(elapsed) >= tsrg_pkg::CMP_BITS'(interval));
      res.dir  = ctl.take ? dir_s1_ff : dir_latch_ff;
      res.step = step;
   end

   // Advance direction latch and last step time on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_latch_ff <= 1'b0;
         step_time_ff <= '0;
      end else if (ctl.commit) begin
         if (ctl.take) begin
            dir_latch_ff <= dir_s1_ff;
         end
         if (step) begin
            step_time_ff <= now;
         end
      end
   end

endmodule

// ----- sv/tsrg_merge.sv -----
// Merge stage: update gate, lane result collection and response register.
module tsrg_merge (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        s1_valid,
   input  tsrg_pkg::time_type                          now,
   input  logic [tsrg_pkg::IVL_BITS-1:0]               update_period,
   input  tsrg_pkg::lane_res_type [tsrg_pkg::LANES-1:0] lane_res,
   output tsrg_pkg::lane_ctl_type                      ctl,
   tsrg_rsp_if.source                                  rsp
);

   logic                          rsp_valid_ff;
   logic                          taken_ff;
   logic [tsrg_pkg::IN_AXES-1:0]  dir_ff;
   logic [tsrg_pkg::IN_AXES-1:0]  step_ff;
   logic [tsrg_pkg::IN_AXES-1:0]  dir_in;
   logic [tsrg_pkg::IN_AXES-1:0]  step_in;
   tsrg_pkg::time_type            last_update_ff;
   tsrg_pkg::time_type            since_update;

   // Gate updates to one per period and commit when the response slot frees
   always_comb begin
      since_update = now - last_update_ff;
      ctl.take     = since_update >= tsrg_pkg::TIME_BITS'(update_period);
      ctl.commit   = s1_valid && (!rsp_valid_ff || rsp.ready);
   end

   // Collect lane results; axes without a lane read zero
   for (genvar i = 0; i < tsrg_pkg::IN_AXES; i++) begin : g_collect
      if (i < tsrg_pkg::LANES) begin : g_lane
         assign dir_in[i]  = lane_res[i].dir;
         assign step_in[i] = lane_res[i].step;
      end else begin : g_none
         assign dir_in[i]  = 1'b0;
         assign step_in[i] = 1'b0;
      end
   end

   // Store the update time when an update is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         last_update_ff <= '0;
      end else if (ctl.commit && ctl.take) begin
         last_update_ff <= now;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         taken_ff <= ctl.take;
         dir_ff   <= dir_in;
         step_ff  <= step_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.update_taken = taken_ff;
   assign rsp.dir_x        = dir_ff[0];
   assign rsp.dir_y        = dir_ff[1];
   assign rsp.dir_z        = dir_ff[2];
   assign rsp.step_x       = step_ff[0];
   assign rsp.step_y       = step_ff[1];
   assign rsp.step_z       = step_ff[2];

endmodule

// ----- sv/three_axis_step_rate_generator.sv -----
// Top level of the three-axis step rate generator.
//
// Takes one timestamped speed transaction per cycle while the response side is
// not stalled and returns one response transaction per request, via the stage
// one and response registers. Stage one maps each axis speed to its step
// interval in a lane of its own (one 16x15 multiply per axis); stage two, the
// merge stage, checks the update period and every axis's elapsed step time
// against the state left by the previous transaction and loads the response
// register. Both gate compares sit in that feedback loop, so back-to-back
// transactions see each other's updates. Configuration registers are written
// through the csr_ port and must only change while no transaction is in flight.
`include "three_axis_step_rate_generator_defines.svh"

module three_axis_step_rate_generator (
   input  logic                                clock,
   input  logic                                reset,
   tsrg_req_if.sink                            req_chan,
   tsrg_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [tsrg_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [tsrg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   tsrg_pkg::cfg_type                           cfg_ff;
   logic                                        s1_valid_ff;
   tsrg_pkg::time_type                          now_s1_ff;
   tsrg_pkg::speed_type                         speed_sel [tsrg_pkg::IN_AXES];
   tsrg_pkg::lane_res_type [tsrg_pkg::LANES-1:0] lane_res;
   tsrg_pkg::lane_ctl_type                      ctl;
   logic                                        load;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone     <= tsrg_pkg::RST_DEAD_ZONE;
         cfg_ff.base_interval <= tsrg_pkg::RST_BASE_INTERVAL;
         cfg_ff.interval_span <= tsrg_pkg::RST_INTERVAL_SPAN;
         cfg_ff.update_period <= tsrg_pkg::RST_UPDATE_PERIOD;
         cfg_ff.swap_xy       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            tsrg_pkg::CSR_DEAD_ZONE: begin
               cfg_ff.dead_zone <= csr_wdata[tsrg_pkg::DZ_BITS-1:0];
            end
            tsrg_pkg::CSR_BASE_INTERVAL: begin
               cfg_ff.base_interval <= csr_wdata[tsrg_pkg::IVL_BITS-1:0];
            end
            tsrg_pkg::CSR_INTERVAL_SPAN: begin
               cfg_ff.interval_span <= csr_wdata[tsrg_pkg::IVL_BITS-1:0];
            end
            tsrg_pkg::CSR_UPDATE_PERIOD: begin
               cfg_ff.update_period <= csr_wdata[tsrg_pkg::IVL_BITS-1:0];
            end
            tsrg_pkg::CSR_SWAP_XY: begin
               cfg_ff.swap_xy <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Accept while stage one is empty or moving on
   assign req_chan.ready = !s1_valid_ff || ctl.commit;
   assign load           = req_chan.valid && req_chan.ready;

   // Optional X/Y exchange ahead of the lanes
   assign speed_sel[0] = cfg_ff.swap_xy ? req_chan.speed_y : req_chan.speed_x;
   assign speed_sel[1] = cfg_ff.swap_xy ? req_chan.speed_x : req_chan.speed_y;
   assign speed_sel[2] = req_chan.speed_z;

   // Stage one occupancy and timestamp
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load) begin
         s1_valid_ff <= 1'b1;
      end else if (ctl.commit) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         now_s1_ff <= tsrg_pkg::TIME_BITS'(req_chan.now_us);
      end
   end

   // Axis lanes
   for (genvar i = 0; i < tsrg_pkg::LANES; i++) begin : g_lane
      tsrg_lane u_lane (
         .clock (clock),
         .reset (reset),
         .load  (load),
         .speed (speed_sel[i]),
         .cfg   (cfg_ff),
         .now   (now_s1_ff),
         .ctl   (ctl),
         .res   (lane_res[i])
      );
   end

   // Update gate and response register
   tsrg_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .s1_valid      (s1_valid_ff),
      .now           (now_s1_ff),
      .update_period (cfg_ff.update_period),
      .lane_res      (lane_res),
      .ctl           (ctl),
      .rsp           (rsp_chan)
   );

   // A new transaction enters a full stage one only when it moves on
   `TSRG_ASSERT(a_s1_no_overwrite, clock, reset, (load && s1_valid_ff) |-> ctl.commit)
   // Every commit presents a response in the next cycle
   `TSRG_ASSERT_NEXT(a_commit_rsp, clock, reset, ctl.commit, rsp_chan.valid)
   // Steps fire only on taken updates
   `TSRG_ASSERT(a_step_needs_update, clock, reset, (rsp_chan.valid && !rsp_chan.update_taken) |-> !(rsp_chan.step_x || rsp_chan.step_y || rsp_chan.step_z))
   // A commit needs a transaction in stage one
   `TSRG_ASSERT(a_commit_has_item, clock, reset, ctl.commit |-> s1_valid_ff)

endmodule
